### design/cdre_pkg.sv
`default_nettype none

package cdre_pkg;

   // Field widths of the date and register items.
   localparam int DAY_W     = 5;
   localparam int MONTH_W   = 4;
   localparam int YEAR_W    = 14;
   localparam int DAY_BCD_W = 6;
   localparam int WDAY_W    = 3;
   localparam int CM_W      = 8;
   localparam int YBCD_W    = 8;

   // Internal widths: year split into century and year within century.
   localparam int YHI_W   = 8;   // full_year / 100, at most 163
   localparam int YLO_W   = 7;   // full_year % 100
   localparam int J_W     = 8;   // century term, at most 167
   localparam int MTERM_W = 6;   // floor(13(m+1)/5), at most 41
   localparam int SUM_W   = 11;  // weekday sum before mod 7, at most 1071

   // Division by 100 as a multiply by a reciprocal; exact for all 14-bit years.
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int PROD_W       = YEAR_W + 13;

   localparam int CENTURY_YEAR = 2000;
   localparam int GREG_OFFSET  = 4;  // 400-year shift, seen as centuries
   localparam int JAN_FEB_LAST = 2;
   localparam int MONTH_WRAP   = 12;

   // Month term of Zeller's congruence, indexed by the adjusted month.
   localparam logic [MTERM_W-1:0] MONTH_TERM [16] = '{
      6'd2,  6'd5,  6'd7,  6'd10, 6'd13, 6'd15, 6'd18, 6'd20,
      6'd23, 6'd26, 6'd28, 6'd31, 6'd33, 6'd36, 6'd39, 6'd41
   };

   typedef struct packed {
      logic [DAY_W-1:0]     day;
      logic [MONTH_W-1:0]   month;
      logic [YEAR_W-1:0]    year;
      logic [YHI_W-1:0]     yhi;
      logic [DAY_BCD_W-1:0] day_bcd;
      logic [CM_W-1:0]      cm_byte;
   } s1_type;

   typedef struct packed {
      logic [DAY_W-1:0]     day;
      logic [MTERM_W-1:0]   mterm;
      logic [YLO_W-1:0]     k;
      logic [J_W-1:0]       j;
      logic [YLO_W-1:0]     ylo;
      logic [DAY_BCD_W-1:0] day_bcd;
      logic [CM_W-1:0]      cm_byte;
   } s2_type;

   typedef struct packed {
      logic [SUM_W-1:0]     sum;
      logic [DAY_BCD_W-1:0] day_bcd;
      logic [CM_W-1:0]      cm_byte;
      logic [YBCD_W-1:0]    year_bcd;
   } s3_type;

   typedef struct packed {
      logic [DAY_BCD_W-1:0] day_bcd;
      logic [WDAY_W-1:0]    weekday_code;
      logic [CM_W-1:0]      century_month_byte;
      logic [YBCD_W-1:0]    year_bcd;
   } rsp_type;

   // Two BCD digits of a value below 100, found with nine parallel compares.
   function automatic logic [7:0] bcd2(input logic [6:0] v);
      logic [3:0] tens;
      logic [6:0] base;
      tens = 4'd0;
      for (int t = 1; t < 10; t++) begin
         if (v >= 7'(10 * t)) begin
            tens = 4'(t);
         end
      end
      base = 7'({3'd0, tens} * 7'd10);
      return {tens, 4'(v - base)};
   endfunction

   // Remainder by 7: since 8 is 1 mod 7, octal digits are summed and folded.
   function automatic logic [2:0] mod7(input logic [SUM_W-1:0] v);
      logic [4:0] f1;
      logic [3:0] f2;
      f1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[10:9]);
      f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
      return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
   endfunction

endpackage

`default_nettype wire

### design/cdre_req_if.sv
`default_nettype none

// Date channel: one calendar date per item.
interface cdre_req_if import cdre_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DAY_W-1:0]   day_of_month;
   logic [MONTH_W-1:0] month_number;
   logic [YEAR_W-1:0]  full_year;

   modport source (output valid, output day_of_month, output month_number,
                   output full_year, input ready);
   modport sink (input valid, input day_of_month, input month_number,
                 input full_year, output ready);
endinterface

`default_nettype wire

### design/cdre_rsp_if.sv
`default_nettype none

// Register channel: day, weekday, century-month and year fields of the clock-chip date registers.
interface cdre_rsp_if import cdre_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DAY_BCD_W-1:0] day_bcd;
   logic [WDAY_W-1:0]    weekday_code;
   logic [CM_W-1:0]      century_month_byte;
   logic [YBCD_W-1:0]    year_bcd;

   modport source (output valid, output day_bcd, output weekday_code,
                   output century_month_byte, output year_bcd, input ready);
   modport sink (input valid, input day_bcd, input weekday_code,
                 input century_month_byte, input year_bcd, output ready);
endinterface

`default_nettype wire

### design/calendar_date_register_encoder.sv
`default_nettype none

// Channel    Direction  Carries
// req_chan   in         day_of_month, month_number, full_year
// rsp_chan   out        day_bcd, weekday_code, century_month_byte, year_bcd
//
// Four register stages in order: split, terms, sum, weekday.
// One date is taken in every cycle while the result side keeps up.
// Each stage holds its item until the next stage frees, so a stall on the
// result side backs up stage by stage without dropping or repeating an item.
// Synchronous reset empties all stages.

module calendar_date_register_encoder import cdre_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   cdre_req_if.sink   req_chan,
   cdre_rsp_if.source rsp_chan
);

   logic    s1_valid, s1_ready;
   logic    s2_valid, s2_ready;
   logic    s3_valid, s3_ready;
   s1_type  s1_data;
   s2_type  s2_data;
   s3_type  s3_data;
   rsp_type rsp_data;

   cdre_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_day    (req_chan.day_of_month),
      .in_month  (req_chan.month_number),
      .in_year   (req_chan.full_year),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   cdre_terms u_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   cdre_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   cdre_weekday u_weekday (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   // Result fields from the output register.
   assign rsp_chan.day_bcd            = rsp_data.day_bcd;
   assign rsp_chan.weekday_code       = rsp_data.weekday_code;
   assign rsp_chan.century_month_byte = rsp_data.century_month_byte;
   assign rsp_chan.year_bcd           = rsp_data.year_bcd;

endmodule

`default_nettype wire

### design/cdre_split.sv
`default_nettype none

// Stage 1: century quotient of the year, day and month BCD, century flag.
module cdre_split import cdre_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output      logic               in_ready,
   input  wire logic [DAY_W-1:0]   in_day,
   input  wire logic [MONTH_W-1:0] in_month,
   input  wire logic [YEAR_W-1:0]  in_year,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      s1_type             out_data
);

   logic         valid_ff;
   s1_type       data_ff;
   s1_type       data_in;
   logic [PROD_W-1:0] prod;
   logic [7:0]   day_digits;
   logic [7:0]   month_digits;

   // The stage takes a new item when empty or when its item moves on.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Year over 100 by reciprocal multiply; small fields go to BCD here.
   always_comb begin
      prod         = PROD_W'(in_year) * PROD_W'(DIV100_MUL);
      day_digits   = bcd2(7'(in_day));
      month_digits = bcd2(7'(in_month));
      data_in.day     = in_day;
      data_in.month   = in_month;
      data_in.year    = in_year;
      data_in.yhi     = prod[DIV100_SHIFT +: YHI_W];
      data_in.day_bcd = day_digits[DAY_BCD_W-1:0];
      data_in.cm_byte = {(in_year >= YEAR_W'(CENTURY_YEAR)), month_digits[CM_W-2:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

### design/cdre_terms.sv
`default_nettype none

// Stage 2: year within century, Zeller's K and J, and the month term.
module cdre_terms import cdre_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output      logic   in_ready,
   input  wire s1_type in_data,
   output      logic   out_valid,
   input  wire logic   out_ready,
   output      s2_type out_data
);

   logic              valid_ff;
   s2_type            data_ff;
   s2_type            data_in;
   logic [YEAR_W-1:0] hundreds;
   logic [YLO_W-1:0]  ylo;
   logic              jan_feb;
   logic [MONTH_W-1:0] month_adj;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // January, February and month zero count as months 13, 14 and 12 of the year before.
   // The year is shifted by 400, so the year before never goes negative.
   always_comb begin
      hundreds  = YEAR_W'(in_data.yhi) * YEAR_W'(100);
      ylo       = YLO_W'(in_data.year - hundreds);
      jan_feb   = (in_data.month <= MONTH_W'(JAN_FEB_LAST));
      month_adj = jan_feb ? MONTH_W'(in_data.month + MONTH_W'(MONTH_WRAP))
                          : in_data.month;
      data_in.day     = in_data.day;
      data_in.mterm   = MONTH_TERM[month_adj];
      data_in.ylo     = ylo;
      data_in.day_bcd = in_data.day_bcd;
      data_in.cm_byte = in_data.cm_byte;
      if (jan_feb && (ylo == '0)) begin
         data_in.k = YLO_W'(99);
         data_in.j = J_W'(in_data.yhi + J_W'(GREG_OFFSET - 1));
      end else if (jan_feb) begin
         data_in.k = ylo - YLO_W'(1);
         data_in.j = J_W'(in_data.yhi + J_W'(GREG_OFFSET));
      end else begin
         data_in.k = ylo;
         data_in.j = J_W'(in_data.yhi + J_W'(GREG_OFFSET));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

### design/cdre_sum.sv
`default_nettype none

// Stage 3: the congruence sum and the year BCD.
module cdre_sum import cdre_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output      logic   in_ready,
   input  wire s2_type in_data,
   output      logic   out_valid,
   input  wire logic   out_ready,
   output      s3_type out_data
);

   logic   valid_ff;
   s3_type data_ff;
   s3_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // q + month term + K + K/4 + J/4 + 5J, the non-negative form.
   always_comb begin
      data_in.sum = SUM_W'(in_data.day) + SUM_W'(in_data.mterm)
                  + SUM_W'(in_data.k) + SUM_W'(in_data.k >> 2)
                  + SUM_W'(in_data.j >> 2) + (SUM_W'(in_data.j) << 2)
                  + SUM_W'(in_data.j);
      data_in.day_bcd  = in_data.day_bcd;
      data_in.cm_byte  = in_data.cm_byte;
      data_in.year_bcd = bcd2(in_data.ylo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

### design/cdre_weekday.sv
`default_nettype none

// Stage 4: remainder by 7, recoded to Sunday first; this is the output register.
module cdre_weekday import cdre_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output      logic    in_ready,
   input  wire s3_type  in_data,
   output      logic    out_valid,
   input  wire logic    out_ready,
   output      rsp_type out_data
);

   logic        valid_ff;
   rsp_type     data_ff;
   rsp_type     data_in;
   logic [2:0]  h;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Zeller gives Saturday as zero; moving back one day puts Sunday at zero.
   always_comb begin
      h = mod7(in_data.sum);
      data_in.weekday_code       = (h == 3'd0) ? 3'd6 : h - 3'd1;
      data_in.day_bcd            = in_data.day_bcd;
      data_in.century_month_byte = in_data.cm_byte;
      data_in.year_bcd           = in_data.year_bcd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

### tb/calendar_date_register_encoder_tb.sv
module calendar_date_register_encoder_tb import cdre_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_DATES  = 1850;
   localparam int TAIL_DATES    = 250;     // no idling once this few are left
   localparam int PRESSURE_AT   = 300;     // dates taken before the long hold-off
   localparam int LONG_HOLD     = 80;
   localparam int DRAIN_CYCLES  = 12;
   localparam int GREG_CYCLE    = 400;     // years in one whole-week Gregorian cycle
   localparam int MARCH         = 3;
   localparam int FEBRUARY      = 2;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_item_type;

   logic clock = 1'b0;
   logic reset;

   cdre_req_if date_chan ();
   cdre_rsp_if regs_chan ();

   calendar_date_register_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (date_chan),
      .rsp_chan (regs_chan)
   );

   date_item_type date_queue[$];
   rsp_type       expected_regs[$];
   int            mismatches = 0;
   int            dates_taken = 0;
   bit            date_taken = 1'b0;
   int            send_gap = 0;
   bit            send_quiet = 1'b0;
   int            hold_left = 0;
   bit            recv_quiet = 1'b0;
   bit            long_hold_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Two BCD digits of a value taken modulo 100.
   function automatic logic [7:0] two_digits(input int unsigned v);
      int unsigned r;
      r = v % 100;
      return {4'(r / 10), 4'(r % 10)};
   endfunction

   // Register bytes of one date; weekday by Zeller's congruence, recoded to Sunday = 0.
   function automatic rsp_type encode_date(input date_item_type d);
      int unsigned q, m, yy, j, k, h;
      rsp_type     r;
      q  = d.day;
      m  = d.month;
      yy = d.year + GREG_CYCLE;
      // January and February (and month zero) count as months of the year before.
      if (m <= FEBRUARY) begin
         m  = m + 12;
         yy = yy - 1;
      end
      j = yy / 100;
      k = yy % 100;
      h = (q + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
      r.weekday_code       = WDAY_W'((h + 6) % 7);
      r.day_bcd            = DAY_BCD_W'(two_digits(d.day));
      r.century_month_byte = two_digits(d.month)
                             | ((d.year >= CENTURY_YEAR) ? 8'h80 : 8'h00);
      r.year_bcd           = two_digits(d.year % 100);
      return r;
   endfunction

   task automatic queue_date(input int day, input int month, input int year);
      date_item_type d;
      d.day   = DAY_W'(day);
      d.month = MONTH_W'(month);
      d.year  = YEAR_W'(year);
      date_queue.push_back(d);
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Sender: presents queued dates at the falling edge, with bursts of idle cycles.
   always @(negedge clock) begin
      if (reset) begin
         date_chan.valid <= 1'b0;
      end else if (!date_chan.valid || date_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            date_chan.valid <= 1'b0;
         end else if (date_queue.size() > 0) begin
            date_chan.day_of_month <= date_queue[0].day;
            date_chan.month_number <= date_queue[0].month;
            date_chan.full_year    <= date_queue[0].year;
            date_chan.valid        <= 1'b1;
            void'(date_queue.pop_front());
            if ($urandom_range(0, 49) == 0) begin
               send_quiet = !send_quiet;
            end
            if (!send_quiet && date_queue.size() > TAIL_DATES
                && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(1, 15);
            end
         end else begin
            date_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off so the pipeline backs up.
   always @(negedge clock) begin
      if (reset) begin
         regs_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         regs_chan.ready <= 1'b0;
      end else if (!long_hold_done && dates_taken >= PRESSURE_AT) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         regs_chan.ready <= 1'b0;
      end else if (!recv_quiet && date_queue.size() > TAIL_DATES
                   && $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(1, 15) - 1;
         regs_chan.ready <= 1'b0;
      end else begin
         regs_chan.ready <= 1'b1;
         if ($urandom_range(0, 49) == 0) begin
            recv_quiet = !recv_quiet;
         end
      end
   end

   // Monitor: predicts each taken date and checks each result against the oldest prediction.
   always @(posedge clock) begin
      rsp_type       want;
      date_item_type d;
      date_taken = 1'b0;
      if (!reset) begin
         if (date_chan.valid && date_chan.ready) begin
            d.day   = date_chan.day_of_month;
            d.month = date_chan.month_number;
            d.year  = date_chan.full_year;
            expected_regs.push_back(encode_date(d));
            date_taken = 1'b1;
            dates_taken++;
         end
         if (regs_chan.valid && regs_chan.ready) begin
            if (expected_regs.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual %0h %0h %0h %0h",
                        $time, regs_chan.day_bcd, regs_chan.weekday_code,
                        regs_chan.century_month_byte, regs_chan.year_bcd);
               mismatches++;
            end else begin
               want = expected_regs.pop_front();
               compare_field("day_bcd", want.day_bcd, regs_chan.day_bcd);
               compare_field("weekday_code", want.weekday_code, regs_chan.weekday_code);
               compare_field("century_month_byte", want.century_month_byte,
                             regs_chan.century_month_byte);
               compare_field("year_bcd", want.year_bcd, regs_chan.year_bcd);
            end
         end
      end
   end

   initial begin
      int day, month, year, month_len;

      date_chan.valid        = 1'b0;
      date_chan.day_of_month = '0;
      date_chan.month_number = '0;
      date_chan.full_year    = '0;
      regs_chan.ready        = 1'b0;
      reset                  = 1'b1;

      // Directed dates: field extremes, year zero in January and February,
      // the century boundary, and unchecked day and month values.
      queue_date(1, 1, 0);
      queue_date(29, 2, 0);
      queue_date(1, 3, 0);
      queue_date(31, 12, 0);
      queue_date(0, 0, 0);
      queue_date(1, 1, 1);
      queue_date(31, 12, 1999);
      queue_date(1, 1, 2000);
      queue_date(29, 2, 2000);
      queue_date(29, 2, 2024);
      queue_date(1, 3, 1900);
      queue_date(4, 7, 1776);
      queue_date(31, 12, 9999);
      queue_date(1, 1, 10000);
      queue_date(15, 6, 16383);
      queue_date(31, 15, 16383);
      queue_date(0, 13, 2024);
      queue_date(30, 14, 1900);
      queue_date(7, 15, 8191);
      queue_date(19, 10, 10101);
      queue_date(12, 2, 100);

      // Random dates: mostly well-formed, the rest raw field noise.
      for (int n = 0; n < RANDOM_DATES; n++) begin
         if ($urandom_range(0, 7) == 0) begin
            queue_date($urandom_range(0, 31), $urandom_range(0, 15),
                       $urandom_range(0, 16383));
         end else begin
            month = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: year = $urandom_range(1900, 2099);
               5, 6, 7:       year = $urandom_range(1, 9999);
               8:             year = $urandom_range(0, 16383);
               default:       year = $urandom_range(1999, 2001);
            endcase
            if (month == FEBRUARY) begin
               month_len = 29;
            end else if (month == 4 || month == 6 || month == 9 || month == 11) begin
               month_len = 30;
            end else begin
               month_len = 31;
            end
            day = $urandom_range(1, month_len);
            if (month < MARCH && $urandom_range(0, 40) == 0) begin
               year = 0;
            end
            queue_date(day, month, year);
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every date to be taken, then for every result, then drain.
      @(posedge clock);
      while (date_queue.size() != 0 || date_chan.valid) begin
         @(posedge clock);
      end
      while (expected_regs.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("calendar_date_register_encoder_tb OK");
      end else begin
         $display("calendar_date_register_encoder_tb NOT OK");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("calendar_date_register_encoder_tb NOT OK");
      $finish;
   end

endmodule
